@@ src/pms_pkg.sv @@
// Shared types, constants and microcode definitions for the periodic message scheduler.
package pms_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int TIME_W       = 40;
    localparam int PERIOD_W     = 32;
    localparam int PHASE_W      = 20;
    localparam int SEQ_W        = 8;
    localparam int SLOT_FIELD_W = 4;
    localparam int IN_TDATA_W   = 80;   // slot + period + time_limit = 76, padded to bytes
    localparam int OUT_TDATA_W  = 56;   // chosen_slot + due_time + sequence_res = 52, padded

    localparam logic [PHASE_W-1:0] PHASE_RESET = 20'd17000;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        STEP_WAIT  = 3'd0,
        STEP_DISP  = 3'd1,
        STEP_SCAN  = 3'd2,
        STEP_CHECK = 3'd3,
        STEP_ADV   = 3'd4,
        STEP_EMIT  = 3'd5
    } step_t;

    // Sequencing: next, goto, branch (cond ? target : next), wait (cond ? target : hold)
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_BRANCH,
        SEQ_WAIT
    } seq_kind_t;

    typedef enum logic [2:0] {
        CND_NONE,
        CND_IN_ACC,
        CND_IS_LOAD,
        CND_SCAN_LAST,
        CND_MISS,
        CND_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_FIRST,
        RD_NEXT,
        RD_BEST
    } rd_sel_t;

    typedef struct packed {
        seq_kind_t seq;
        cond_t     cond;
        step_t     target;
        logic      take_in;    // accept a request
        logic      scan_init;  // clear best, reset scan index and result
        logic      load_wr;    // write slot period on a load request
        rd_sel_t   rd;         // slot memory read address select
        logic      scan_cmp;   // compare one slot against best
        logic      check;      // test best against time limit, form result
        logic      advance;    // move chosen slot by its period
        logic      emit;       // hand result to the output register
    } ctrl_word_t;

    typedef struct packed {
        logic in_acc;
        logic is_load;
        logic scan_last;
        logic miss;
        logic out_free;
    } pms_flags_t;

endpackage

@@ src/pms_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module pms_seq
    import pms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pms_flags_t flags,
    output ctrl_word_t ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  cond_ok;

    // Control ROM
    always_comb
    begin
        ctrl.seq       = SEQ_GOTO;
        ctrl.cond      = CND_NONE;
        ctrl.target    = STEP_WAIT;
        ctrl.take_in   = 1'b0;
        ctrl.scan_init = 1'b0;
        ctrl.load_wr   = 1'b0;
        ctrl.rd        = RD_NONE;
        ctrl.scan_cmp  = 1'b0;
        ctrl.check     = 1'b0;
        ctrl.advance   = 1'b0;
        ctrl.emit      = 1'b0;
        unique case (pc_reg)
            STEP_WAIT:
            begin
                ctrl.seq     = SEQ_WAIT;
                ctrl.cond    = CND_IN_ACC;
                ctrl.target  = STEP_DISP;
                ctrl.take_in = 1'b1;
            end
            STEP_DISP:
            begin
                ctrl.seq       = SEQ_BRANCH;
                ctrl.cond      = CND_IS_LOAD;
                ctrl.target    = STEP_EMIT;
                ctrl.scan_init = 1'b1;
                ctrl.load_wr   = 1'b1;
                ctrl.rd        = RD_FIRST;
            end
            STEP_SCAN:
            begin
                ctrl.seq      = SEQ_WAIT;
                ctrl.cond     = CND_SCAN_LAST;
                ctrl.target   = STEP_CHECK;
                ctrl.rd       = RD_NEXT;
                ctrl.scan_cmp = 1'b1;
            end
            STEP_CHECK:
            begin
                ctrl.seq    = SEQ_BRANCH;
                ctrl.cond   = CND_MISS;
                ctrl.target = STEP_EMIT;
                ctrl.rd     = RD_BEST;
                ctrl.check  = 1'b1;
            end
            STEP_ADV:
            begin
                ctrl.seq     = SEQ_NEXT;
                ctrl.advance = 1'b1;
            end
            STEP_EMIT:
            begin
                ctrl.seq    = SEQ_WAIT;
                ctrl.cond   = CND_OUT_FREE;
                ctrl.target = STEP_WAIT;
                ctrl.emit   = 1'b1;
            end
            default:
            begin
                ctrl.seq    = SEQ_GOTO;
                ctrl.target = STEP_WAIT;
            end
        endcase
    end

    always_comb
    begin
        unique case (ctrl.cond)
            CND_NONE:      cond_ok = 1'b1;
            CND_IN_ACC:    cond_ok = flags.in_acc;
            CND_IS_LOAD:   cond_ok = flags.is_load;
            CND_SCAN_LAST: cond_ok = flags.scan_last;
            CND_MISS:      cond_ok = flags.miss;
            CND_OUT_FREE:  cond_ok = flags.out_free;
            default:       cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.seq)
            SEQ_NEXT:   pc_next = step_t'(pc_reg + 3'd1);
            SEQ_GOTO:   pc_next = ctrl.target;
            SEQ_BRANCH: pc_next = cond_ok ? ctrl.target : step_t'(pc_reg + 3'd1);
            SEQ_WAIT:   pc_next = cond_ok ? ctrl.target : pc_reg;
            default:    pc_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/periodic_message_scheduler_core.sv @@
// Top level of the periodic message scheduler: slot tables, scan datapath and stream ports.
//
// Flow: a load request goes from dispatch straight to emit; a schedule request scans every slot,
// checks the best against its time limit, advances the chosen slot when one fires, then emits.
// A new request is taken only after the last one has been emitted; the scan reads one slot per
// cycle through the due-time memory port.
// Reset: all slots inactive, sequence number 0, phase_step 17000; slot memories hold no reset.
module periodic_message_scheduler_core
    import pms_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [PHASE_W-1:0]     cfg_wr_data,      // phase_step
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,     // [3:0] slot, [35:4] period,
                                                     // [75:36] time_limit, [79:76] zero
    input  logic                   s_axis_tuser,     // [0] mode
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,     // [3:0] chosen_slot, [43:4] due_time,
                                                     // [51:44] sequence_res, [55:52] zero
    output logic                   m_axis_tuser      // [0] found
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    ctrl_word_t ctrl;
    pms_flags_t flags;

    // Latched request fields
    logic                    lat_mode;
    logic [SLOT_FIELD_W-1:0] lat_slot;
    logic [PERIOD_W-1:0]     lat_period;
    logic [TIME_W-1:0]       lat_limit;

    logic [PHASE_W-1:0] phase_reg;

    // Slot tables: active bits in flops, due times and periods in memories
    logic [SLOTS-1:0]    active_reg;
    logic [TIME_W-1:0]   due_mem [SLOTS];
    logic [PERIOD_W-1:0] period_mem [SLOTS];
    logic [TIME_W-1:0]   due_rd_reg;
    logic [PERIOD_W-1:0] period_rd_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              due_we;
    logic [SLOT_W-1:0] due_wa;
    logic [TIME_W-1:0] due_wd;
    logic              ld_ok;
    logic [SLOT_W-1:0] ld_idx;
    logic [PHASE_W+SLOT_FIELD_W-1:0] ld_offset;
    logic [TIME_W:0]   adv_sum;

    // Scan state
    logic [SLOT_W-1:0] idx_reg;
    logic              best_valid_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [TIME_W-1:0] best_t_reg;
    logic              hit;
    logic [SEQ_W-1:0]  seq_reg;

    // Result staging and output register
    logic                    res_found_reg;
    logic [SLOT_FIELD_W-1:0] res_slot_reg;
    logic [TIME_W-1:0]       res_due_reg;
    logic [SEQ_W-1:0]        res_seq_reg;
    logic                    m_valid_reg;
    logic                    m_found_reg;
    logic [SLOT_FIELD_W-1:0] m_slot_reg;
    logic [TIME_W-1:0]       m_due_reg;
    logic [SEQ_W-1:0]        m_seq_reg;

    pms_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Ready only at the wait step; the output register lets a result sit while the next
    // request is taken.
    assign s_axis_tready = ctrl.take_in;

    assign hit = best_valid_reg && (best_t_reg <= lat_limit);

    always_comb
    begin
        flags.in_acc    = s_axis_tvalid && s_axis_tready;
        flags.is_load   = !lat_mode;
        flags.scan_last = (idx_reg == LAST_IDX);
        flags.miss      = !hit;
        flags.out_free  = !m_valid_reg || m_axis_tready;
    end

    // Load path: slot index in range, first due time is slot times phase step
    assign ld_ok     = ({{(32-SLOT_FIELD_W){1'b0}}, lat_slot} < 32'(SLOTS));
    assign ld_idx    = SLOT_W'(lat_slot);
    assign ld_offset = PHASE_W'(phase_reg) * SLOT_FIELD_W'(lat_slot);

    // Advance: carry out of 40 bits retires the slot
    assign adv_sum = {1'b0, best_t_reg} + {{(TIME_W+1-PERIOD_W){1'b0}}, period_rd_reg};

    // Memory read address select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (ctrl.rd)
            RD_FIRST:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            RD_NEXT:
            begin
                rd_en   = !flags.scan_last;
                rd_addr = SLOT_W'(idx_reg + 1'b1);
            end
            RD_BEST:
            begin
                rd_en   = 1'b1;
                rd_addr = best_idx_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Due-time write port, shared by load and advance
    always_comb
    begin
        due_we = 1'b0;
        due_wa = best_idx_reg;
        due_wd = adv_sum[TIME_W-1:0];
        if (ctrl.load_wr && !lat_mode && ld_ok)
        begin
            due_we = 1'b1;
            due_wa = ld_idx;
            due_wd = (lat_period != '0) ? TIME_W'(ld_offset) : '0;
        end
        else if (ctrl.advance)
        begin
            due_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_wa] <= due_wd;
        end
        if (rd_en)
        begin
            due_rd_reg <= due_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_wr && !lat_mode && ld_ok)
        begin
            period_mem[ld_idx] <= lat_period;
        end
        if (rd_en)
        begin
            period_rd_reg <= period_mem[rd_addr];
        end
    end

    // Latch the request payload on acceptance
    always_ff @(posedge clk)
    begin
        if (flags.in_acc)
        begin
            lat_mode   <= s_axis_tuser;
            lat_slot   <= s_axis_tdata[3:0];
            lat_period <= s_axis_tdata[35:4];
            lat_limit  <= s_axis_tdata[75:36];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            phase_reg <= cfg_wr_data;
        end
    end

    // Active bits: set or clear on load, drop when the due time overflows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (ctrl.load_wr && !lat_mode && ld_ok)
        begin
            active_reg[ld_idx] <= (lat_period != '0);
        end
        else if (ctrl.advance && adv_sum[TIME_W])
        begin
            active_reg[best_idx_reg] <= 1'b0;
        end
    end

    // Scan: one slot per cycle, strict less-than keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (ctrl.scan_init)
        begin
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (ctrl.scan_cmp)
        begin
            if (!flags.scan_last)
            begin
                idx_reg <= SLOT_W'(idx_reg + 1'b1);
            end
            if (active_reg[idx_reg] && (!best_valid_reg || (due_rd_reg < best_t_reg)))
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_cmp && active_reg[idx_reg] &&
            (!best_valid_reg || (due_rd_reg < best_t_reg)))
        begin
            best_idx_reg <= idx_reg;
            best_t_reg   <= due_rd_reg;
        end
    end

    // Sequence number: report, then advance on every scheduled message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
        end
        else if (ctrl.check && hit)
        begin
            seq_reg <= SEQ_W'(seq_reg + 1'b1);
        end
    end

    // Result staging: cleared at dispatch, filled by the limit check
    always_ff @(posedge clk)
    begin
        if (ctrl.scan_init)
        begin
            res_found_reg <= 1'b0;
            res_slot_reg  <= '0;
            res_due_reg   <= '0;
            res_seq_reg   <= '0;
        end
        else if (ctrl.check && hit)
        begin
            res_found_reg <= 1'b1;
            res_slot_reg  <= SLOT_FIELD_W'(best_idx_reg);
            res_due_reg   <= best_t_reg;
            res_seq_reg   <= seq_reg;
        end
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctrl.emit && flags.out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit && flags.out_free)
        begin
            m_found_reg <= res_found_reg;
            m_slot_reg  <= res_slot_reg;
            m_due_reg   <= res_due_reg;
            m_seq_reg   <= res_seq_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = {4'b0000, m_seq_reg, m_due_reg, m_slot_reg};

    // Scan index steps by one until the last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.scan_cmp && !flags.scan_last) |=> (idx_reg == SLOT_W'($past(idx_reg) + 1'b1)))
        else $error("scan index did not advance by one");

    // Only an active slot is ever advanced
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |-> active_reg[best_idx_reg])
        else $error("advancing an inactive slot");

    // A scheduled message never exceeds the request's time limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && flags.out_free && res_found_reg) |-> (res_due_reg <= lat_limit))
        else $error("emitted due time exceeds limit");

    // Each scheduled message bumps the sequence number by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.check && hit) |=> (seq_reg == SEQ_W'($past(seq_reg) + 1'b1)))
        else $error("sequence number did not increment");

endmodule
